### sv/sobel_edge_threshold_unit_macros.svh
// assertion macros for the sobel edge threshold unit
`ifndef SOBEL_EDGE_THRESHOLD_UNIT_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SET_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("sobel edge threshold unit: same-cycle check failed");

// next-cycle implication, disabled in reset
`define SET_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("sobel edge threshold unit: next-cycle check failed");

`endif

### sv/sobel_et_pkg.sv
// shared constants for the sobel edge threshold unit
package sobel_et_pkg;

  // payload and register widths
  localparam int PIX_W   = 8;
  localparam int CRD_W   = 10;
  localparam int REG_W   = 11;
  localparam int CIDX_W  = 2;
  localparam int GRAD_W  = 12;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_LINE_WIDTH     = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  // register reset values
  localparam logic [REG_W-1:0] LINE_WIDTH_RST     = 11'd240;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST   = 11'd416;
  localparam logic [REG_W-1:0] EDGE_THRESHOLD_RST = 11'd85;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

endpackage

### sv/sobel_edge_threshold_unit.sv
// sobel 3x3 edge detector with l1 magnitude threshold, streaming top level
// an accepted pixel beat is registered in the first stage, then in the result register
// throughput: one pixel per cycle while the output is not stalled; line stores are single-write, single-read memories
// border pixels give no result beat, so output beats per frame are (w-2)*(h-2)
// reset: sizes and threshold to 240/416/85, position counters to zero, pipeline empty
// line stores and window taps have no reset and are filled by the first two rows
`include "sobel_edge_threshold_unit_macros.svh"

module sobel_edge_threshold_unit
  import sobel_et_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  // pixel input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  gray_value,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic              edge_flag,
  output logic [CRD_W-1:0]  center_col,
  output logic [CRD_W-1:0]  center_row,
  output logic              frame_done,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // configuration registers
  logic [REG_W-1:0] line_width;
  logic [REG_W-1:0] frame_height;
  logic [REG_W-1:0] edge_threshold;

  // position of the next pixel
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;

  // line stores and window
  pix_t line_store_older [MAX_WIDTH];
  pix_t line_store_newer [MAX_WIDTH];
  pix_t window_taps [6];

  // first stage
  logic          s1_valid;
  pix_t          s1_pixel;
  pix_t          s1_top;
  pix_t          s1_mid;
  logic [CW-1:0] s1_col;
  logic [CW-1:0] s1_col_m1;
  logic [RW-1:0] s1_row_m1;
  logic          s1_interior;
  logic          s1_last;

  // handshake and control
  logic          out_en;
  logic          s1_en;
  logic          accept;
  logic          s1_leave;
  logic          cfg_write;
  logic          size_write;
  logic [WW-1:0] line_w;
  logic [HW-1:0] frame_h;
  logic          col_last;
  logic          row_last;

  // gradient datapath
  grad_t             gx;
  grad_t             gy;
  logic [REG_W-1:0]  gx_abs;
  logic [REG_W-1:0]  gy_abs;
  logic [REG_W-1:0]  mag;

  // stage enables
  assign out_en   = !out_valid || !out_stall;
  assign s1_en    = !s1_valid || out_en;
  assign in_stall = !s1_en;
  assign accept   = in_valid && s1_en;
  assign s1_leave = s1_valid && out_en;

  // configuration port always ready
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign size_write = cfg_write &&
                      (cfg_index == REG_LINE_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= LINE_WIDTH_RST;
      frame_height   <= FRAME_HEIGHT_RST;
      edge_threshold <= EDGE_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LINE_WIDTH:     line_width     <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data;
        default:            ;
      endcase
    end
  end

  // sizes saturated to the supported range
  always_comb begin
    if (line_width < REG_W'(3)) begin
      line_w = WW'(3);
    end else if (32'(line_width) > MAX_WIDTH) begin
      line_w = WW'(MAX_WIDTH);
    end else begin
      line_w = WW'(line_width);
    end
    if (frame_height < REG_W'(3)) begin
      frame_h = HW'(3);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      frame_h = HW'(MAX_HEIGHT);
    end else begin
      frame_h = HW'(frame_height);
    end
  end

  assign col_last = (WW'(column_count) + WW'(1)) == line_w;
  assign row_last = (HW'(row_count) + HW'(1)) == frame_h;

  // raster position counters, restarted by a size write
  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // line store read, registered into the first stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_top <= line_store_older[column_count];
      s1_mid <= line_store_newer[column_count];
    end
  end

  // line store write as the pixel leaves the first stage
  always_ff @(posedge clk) begin
    if (s1_leave) begin
      line_store_older[s1_col] <= s1_mid;
      line_store_newer[s1_col] <= s1_pixel;
    end
  end

  // window shift as the pixel leaves the first stage
  always_ff @(posedge clk) begin
    if (s1_leave) begin
      window_taps[0] <= window_taps[3];
      window_taps[1] <= window_taps[4];
      window_taps[2] <= window_taps[5];
      window_taps[3] <= s1_top;
      window_taps[4] <= s1_mid;
      window_taps[5] <= s1_pixel;
    end
  end

  // first stage control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= gray_value;
      s1_col      <= column_count;
      s1_col_m1   <= column_count - CW'(1);
      s1_row_m1   <= row_count - RW'(1);
      s1_interior <= (column_count >= CW'(2)) && (row_count >= RW'(2));
      s1_last     <= col_last && row_last;
    end
  end

  // sobel gradients on the full window
  always_comb begin
    gx = - grad_t'(window_taps[0]) + grad_t'(s1_top)
         - (grad_t'(window_taps[1]) <<< 1) + (grad_t'(s1_mid) <<< 1)
         - grad_t'(window_taps[2]) + grad_t'(s1_pixel);
    gy =   grad_t'(window_taps[0]) + (grad_t'(window_taps[3]) <<< 1) + grad_t'(s1_top)
         - grad_t'(window_taps[2]) - (grad_t'(window_taps[5]) <<< 1) - grad_t'(s1_pixel);
    gx_abs = gx[GRAD_W-1] ? REG_W'(-gx) : REG_W'(gx);
    gy_abs = gy[GRAD_W-1] ? REG_W'(-gy) : REG_W'(gy);
    mag    = gx_abs + gy_abs;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid && s1_interior;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      edge_flag  <= mag > edge_threshold;
      center_col <= CRD_W'(s1_col_m1);
      center_row <= CRD_W'(s1_row_m1);
      frame_done <= s1_last;
    end
  end

  // a size write restarts the frame
  `SET_ASSERT_NEXT(a_size_write_restarts, clk, rst, size_write,
                   column_count == '0 && row_count == '0)
  // the column counter never reaches the row width
  `SET_ASSERT_SAME(a_column_in_range, clk, rst, 1'b1,
                   WW'(column_count) < line_w)
  // the input stalls only when both stages are full and the output is held
  `SET_ASSERT_SAME(a_stall_only_when_full, clk, rst, in_stall,
                   s1_valid && out_valid && out_stall)
  // a held first stage keeps its pixel and position
  `SET_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !out_en,
                   s1_valid && $stable(s1_col) && $stable(s1_pixel))

endmodule
